// ----- rtl/packed_sample_unpacker_defines.svh -----
// Assertion macros used by the checker file of the unpacker.
`ifndef PACKED_SAMPLE_UNPACKER_DEFINES_SVH
`define PACKED_SAMPLE_UNPACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/psu_pkg.sv -----
package psu_pkg;

  localparam int BYTE_W     = 8;
  localparam int AVAIL_W    = 4;
  localparam int VALUE_W    = 32;
  localparam int INDEX_W    = 24;
  localparam int COUNT_W    = 25;
  localparam int CFG_SB_W   = 6;
  localparam int CFG_STR_W  = 3;
  localparam int CFG_OFS_W  = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int EFF_SB_W   = 7;
  localparam int EFF_STR_W  = 4;

  localparam int SAMPLE_BITS_RST = 8;
  localparam int STRIDE_RST      = 1;
  localparam int OFFSET_RST      = 0;
  localparam int PIXEL_COUNT_RST = 65536;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_EXCESS = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_BITS,
    REG_CHANNEL_STRIDE,
    REG_CHANNEL_OFFSET,
    REG_PIXEL_COUNT
  } psu_reg_t;

  typedef struct packed {
    logic [EFF_SB_W-1:0]  sample_bits;
    logic [EFF_STR_W-1:0] stride;
    logic [CFG_OFS_W-1:0] offset;
    logic [COUNT_W-1:0]   count;
  } psu_eff_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] sample_value;
    logic [INDEX_W-1:0] pixel_index;
    logic               frame_last;
    logic               run_last;
  } psu_res_t;

endpackage

// ----- rtl/psu_front.sv -----
module psu_front #(
  parameter int MAX_SAMPLE_BITS  = 32,
  parameter int PIXEL_INDEX_BITS = 24,
  parameter int MAX_STRIDE       = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output psu_pkg::psu_eff_t                eff
);

  localparam int LIM_W = 31;
  localparam logic [psu_pkg::EFF_SB_W-1:0]  SB_MAX  = psu_pkg::EFF_SB_W'(MAX_SAMPLE_BITS);
  localparam logic [psu_pkg::EFF_STR_W-1:0] STR_MAX = psu_pkg::EFF_STR_W'(MAX_STRIDE);
  localparam logic [LIM_W-1:0]              CNT_LIM = LIM_W'(1) << PIXEL_INDEX_BITS;

  logic [psu_pkg::CFG_SB_W-1:0]  sb_r;
  logic [psu_pkg::CFG_STR_W-1:0] str_r;
  logic [psu_pkg::CFG_OFS_W-1:0] ofs_r;
  logic [psu_pkg::COUNT_W-1:0]   pc_r;

  logic [psu_pkg::EFF_SB_W-1:0]  sb_ext;
  logic [psu_pkg::EFF_STR_W-1:0] str_ext;
  logic [LIM_W-1:0]              pc_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r  <= psu_pkg::CFG_SB_W'(psu_pkg::SAMPLE_BITS_RST);
      str_r <= psu_pkg::CFG_STR_W'(psu_pkg::STRIDE_RST);
      ofs_r <= psu_pkg::CFG_OFS_W'(psu_pkg::OFFSET_RST);
      pc_r  <= psu_pkg::COUNT_W'(psu_pkg::PIXEL_COUNT_RST);
    end else if (cfg_valid) begin
      case (psu_pkg::psu_reg_t'(cfg_index))
        psu_pkg::REG_SAMPLE_BITS:    sb_r  <= cfg_wdata[psu_pkg::CFG_SB_W-1:0];
        psu_pkg::REG_CHANNEL_STRIDE: str_r <= cfg_wdata[psu_pkg::CFG_STR_W-1:0];
        psu_pkg::REG_CHANNEL_OFFSET: ofs_r <= cfg_wdata[psu_pkg::CFG_OFS_W-1:0];
        psu_pkg::REG_PIXEL_COUNT:    pc_r  <= cfg_wdata[psu_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign sb_ext  = psu_pkg::EFF_SB_W'(sb_r);
  assign str_ext = psu_pkg::EFF_STR_W'(str_r);
  assign pc_ext  = LIM_W'(pc_r);

  // Out-of-range sample_bits, stride and count settings are clamped here; the offset is passed on as written.
  always_comb begin
    eff.offset = ofs_r;
    if (sb_r == '0) begin
      eff.sample_bits = psu_pkg::EFF_SB_W'(1);
    end else if (sb_ext > SB_MAX) begin
      eff.sample_bits = SB_MAX;
    end else begin
      eff.sample_bits = sb_ext;
    end
    if (str_r == '0) begin
      eff.stride = psu_pkg::EFF_STR_W'(1);
    end else if (str_ext > STR_MAX) begin
      eff.stride = STR_MAX;
    end else begin
      eff.stride = str_ext;
    end
    if (pc_r == '0) begin
      eff.count = psu_pkg::COUNT_W'(1);
    end else if (pc_ext > CNT_LIM) begin
      eff.count = psu_pkg::COUNT_W'(CNT_LIM);
    end else begin
      eff.count = pc_r;
    end
  end

endmodule

// ----- rtl/psu_queue.sv -----
module psu_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  output logic [WIDTH-1:0] rd_data,
  input  logic             rd_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  assign wr_ready = count_r != CNT_W'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_pop && rd_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/psu_back.sv -----
module psu_back #(
  parameter int MAX_SAMPLE_BITS  = 32,
  parameter int PIXEL_INDEX_BITS = 24,
  parameter int MAX_STRIDE       = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  psu_pkg::psu_eff_t            eff,
  input  logic                         head_valid,
  input  logic [psu_pkg::BYTE_W-1:0]   head_byte,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output psu_pkg::psu_res_t            out_res
);

  localparam int NEED_W = $clog2(MAX_SAMPLE_BITS + 1);
  localparam int PH_W   = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
  localparam int CMP_W  = psu_pkg::EFF_STR_W + 1;
  localparam int CI_W   = psu_pkg::COUNT_W + 1;
  localparam logic [psu_pkg::COUNT_W-1:0] IDX_MASK =
    psu_pkg::COUNT_W'((64'(1) << PIXEL_INDEX_BITS) - 64'(1));
  localparam logic [psu_pkg::AVAIL_W-1:0] FULL_BYTE = psu_pkg::AVAIL_W'(psu_pkg::BYTE_W);
  localparam logic [psu_pkg::BYTE_W-1:0]  ONES      = {psu_pkg::BYTE_W{1'b1}};

  logic [psu_pkg::AVAIL_W-1:0] avail_r, avail_nxt;
  logic [NEED_W-1:0]           need_r, need_nxt;
  logic [psu_pkg::VALUE_W-1:0] part_r, part_nxt;
  logic [PH_W-1:0]             phase_r, phase_nxt;
  logic [psu_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic                        done_r, done_nxt;
  logic                        pend_v_r, pend_v_nxt;
  logic                        pend_done_r, pend_done_nxt;
  psu_pkg::psu_res_t           pend_r, pend_nxt;
  logic                        out_v_r, out_v_nxt;
  psu_pkg::psu_res_t           out_r, out_nxt;

  logic [NEED_W-1:0]           w;
  logic                        can_push;
  logic                        go;
  logic                        first;
  logic                        at_count;
  logic [psu_pkg::AVAIL_W-1:0] take;
  logic [psu_pkg::AVAIL_W-1:0] rem;
  logic [psu_pkg::BYTE_W-1:0]  chunk;
  logic [psu_pkg::VALUE_W-1:0] part_sh;
  logic [psu_pkg::VALUE_W-1:0] trail;
  logic                        complete;
  logic                        kept;
  logic [CMP_W-1:0]            phase_inc;
  logic                        wrap;
  logic [CI_W-1:0]             cnt_inc;
  logic                        last_group;
  logic                        fin;
  logic                        new_v;
  psu_pkg::psu_res_t           new_res;
  logic                        push;
  psu_pkg::psu_res_t           push_res;

  assign w          = NEED_W'(eff.sample_bits);
  assign can_push   = !out_v_r || out_ready;
  assign go         = head_valid && can_push && !pend_done_r;
  assign first      = avail_r == FULL_BYTE;
  assign at_count   = cnt_r >= eff.count;
  assign take       = (need_r < NEED_W'(avail_r)) ? psu_pkg::AVAIL_W'(need_r) : avail_r;
  assign rem        = avail_r - take;
  assign chunk      = (head_byte >> rem) & ~(ONES << take);
  assign part_sh    = (part_r << take) | psu_pkg::VALUE_W'(chunk);
  assign trail      = psu_pkg::VALUE_W'(head_byte & ~(ONES << rem));
  assign complete   = need_r == NEED_W'(take);
  assign kept       = CMP_W'(phase_r) == CMP_W'(eff.offset);
  assign phase_inc  = CMP_W'(phase_r) + CMP_W'(1);
  assign wrap       = phase_inc >= CMP_W'(eff.stride);
  assign cnt_inc    = CI_W'(cnt_r) + CI_W'(1);
  assign last_group = cnt_inc >= CI_W'(eff.count);

  // Each step completes at most one sample of the head byte and soaks up any
  // trailing bits that cannot finish another one.
  always_comb begin
    avail_nxt     = avail_r;
    need_nxt      = need_r;
    part_nxt      = part_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    fin           = 1'b0;
    new_v         = 1'b0;
    new_res       = '0;
    if (go) begin
      if (first && (done_r || at_count)) begin
        done_nxt         = 1'b1;
        new_v            = 1'b1;
        new_res.kind     = psu_pkg::KIND_EXCESS;
        new_res.run_last = 1'b1;
        fin              = 1'b1;
      end else if (!complete) begin
        part_nxt = part_sh;
        need_nxt = need_r - NEED_W'(take);
        fin      = 1'b1;
      end else begin
        new_v               = kept;
        new_res.kind        = psu_pkg::KIND_SAMPLE;
        new_res.sample_value = part_sh;
        new_res.pixel_index = psu_pkg::INDEX_W'(cnt_r & IDX_MASK);
        new_res.frame_last  = last_group;
        part_nxt            = '0;
        need_nxt            = w;
        if (wrap) begin
          phase_nxt = '0;
          cnt_nxt   = cnt_inc[psu_pkg::COUNT_W-1:0];
        end else begin
          phase_nxt = phase_inc[PH_W-1:0];
        end
        if (wrap && last_group) begin
          done_nxt = 1'b1;
          fin      = 1'b1;
        end else if (rem == '0) begin
          fin = 1'b1;
        end else if (NEED_W'(rem) < w) begin
          part_nxt = trail;
          need_nxt = w - NEED_W'(rem);
          fin      = 1'b1;
        end else begin
          avail_nxt = rem;
        end
      end
      if (fin) begin
        avail_nxt = FULL_BYTE;
      end
    end
  end

  assign pop = go && fin;

  // A kept sample waits in the pending slot until it is known whether the
  // same byte yields another one, which settles its run_last flag.
  always_comb begin
    push          = 1'b0;
    push_res      = pend_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    pend_done_nxt = pend_done_r;
    if (pend_done_r) begin
      if (can_push) begin
        push          = 1'b1;
        pend_v_nxt    = 1'b0;
        pend_done_nxt = 1'b0;
      end
    end else if (go) begin
      if (new_v) begin
        if (pend_v_r) begin
          push              = 1'b1;
          push_res.run_last = 1'b0;
          pend_nxt          = new_res;
          pend_nxt.run_last = fin;
          pend_done_nxt     = fin;
        end else if (fin) begin
          push              = 1'b1;
          push_res          = new_res;
          push_res.run_last = 1'b1;
        end else begin
          pend_nxt   = new_res;
          pend_v_nxt = 1'b1;
        end
      end else if (fin && pend_v_r) begin
        push              = 1'b1;
        push_res.run_last = 1'b1;
        pend_v_nxt        = 1'b0;
      end
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (can_push) begin
      out_v_nxt = push;
      if (push) begin
        out_nxt = push_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avail_r     <= FULL_BYTE;
      need_r      <= NEED_W'(psu_pkg::SAMPLE_BITS_RST);
      part_r      <= '0;
      phase_r     <= '0;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      pend_v_r    <= 1'b0;
      pend_done_r <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      avail_r     <= avail_nxt;
      need_r      <= need_nxt;
      part_r      <= part_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      pend_v_r    <= pend_v_nxt;
      pend_done_r <= pend_done_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_res   = out_r;

endmodule

// ----- rtl/packed_sample_unpacker.sv -----
// Unpacks MSB-first samples of 1 to 32 bits from a stream of raw bytes.
// Input channel: one byte per transaction on in_data_byte (in_valid/in_ready).
// Output channel: one result per transaction; kind 0 is a kept sample with its
// pixel index, kind 1 flags a byte that arrived after the frame was complete.
// run_last marks the final result caused by a byte; frame_last the final pixel.
// Configuration channel: cfg_index selects sample_bits, channel_stride,
// channel_offset or pixel_count; cfg_ready is always high.
// Bytes pass through a four-entry queue into the unpacking engine, which
// handles one sample completion per cycle while the output is not stalled
// and feeds an output register. With the queue empty, a byte is registered in
// the queue, then its first result in the output register; a kept sample
// that more of the same byte may follow is held until the next completion.
// At eight or more bits per sample a byte is taken every cycle while the
// output is not stalled. Narrower samples hold a byte at the queue head until
// each sample it completes is handled; the engine also pauses when the final
// step completes a kept sample while an earlier one of the byte is held back.
// Synchronous reset restores the default configuration and starts a new frame.
// When the receiver stalls the output register holds its result, the engine
// waits and the queue fills, after which in_ready falls.
module packed_sample_unpacker #(
  parameter int MAX_SAMPLE_BITS  = 32,
  parameter int PIXEL_INDEX_BITS = 24,
  parameter int MAX_STRIDE       = 4
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [psu_pkg::BYTE_W-1:0]     in_data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [psu_pkg::VALUE_W-1:0]    out_sample_value,
  output logic [psu_pkg::INDEX_W-1:0]    out_pixel_index,
  output logic                           out_frame_last,
  output logic                           out_run_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [psu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [psu_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int QUEUE_DEPTH = 4;

  psu_pkg::psu_eff_t          eff;
  logic                       head_valid;
  logic [psu_pkg::BYTE_W-1:0] head_byte;
  logic                       head_pop;
  psu_pkg::psu_res_t          res;

  psu_front #(
    .MAX_SAMPLE_BITS (MAX_SAMPLE_BITS),
    .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS),
    .MAX_STRIDE      (MAX_STRIDE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .eff      (eff)
  );

  psu_queue #(
    .WIDTH(psu_pkg::BYTE_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(in_valid),
    .wr_ready(in_ready),
    .wr_data (in_data_byte),
    .rd_valid(head_valid),
    .rd_data (head_byte),
    .rd_pop  (head_pop)
  );

  psu_back #(
    .MAX_SAMPLE_BITS (MAX_SAMPLE_BITS),
    .PIXEL_INDEX_BITS(PIXEL_INDEX_BITS),
    .MAX_STRIDE      (MAX_STRIDE)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff       (eff),
    .head_valid(head_valid),
    .head_byte (head_byte),
    .pop       (head_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_kind         = res.kind;
  assign out_sample_value = res.sample_value;
  assign out_pixel_index  = res.pixel_index;
  assign out_frame_last   = res.frame_last;
  assign out_run_last     = res.run_last;

endmodule

// ----- rtl/psu_checker.sv -----
`include "packed_sample_unpacker_defines.svh"

module psu_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_kind,
  input logic [psu_pkg::VALUE_W-1:0] out_sample_value,
  input logic [psu_pkg::INDEX_W-1:0] out_pixel_index,
  input logic                        out_frame_last,
  input logic                        out_run_last
);

  `PSU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kind) && $stable(out_sample_value) && $stable(out_pixel_index) && $stable(out_frame_last) && $stable(out_run_last), "Output transaction changed while stalled")
  `PSU_ASSERT_NOW(a_excess_shape, out_valid && out_kind == psu_pkg::KIND_EXCESS, out_run_last && out_sample_value == '0 && out_pixel_index == '0 && !out_frame_last, "Excess result is not a lone zero result")
  `PSU_ASSERT_NOW(a_frame_end_run, out_valid && out_kind == psu_pkg::KIND_SAMPLE && out_frame_last, out_run_last, "Final pixel does not close its byte")
  `PSU_ASSERT_NOW(a_reset_idle, $past(!rst_n), !out_valid, "Output valid straight after reset")

endmodule

bind packed_sample_unpacker psu_checker u_psu_checker (.*);
